// ===== hw/rtl/erm_pkg.sv =====
// erm_pkg: shared types, constants and tables for the rotation matrix builder
// transaction structs, controller states, command struct, cordic arctangent table
// no dependencies
`timescale 1ns / 1ps

package erm_pkg;

   localparam logic [1:0] CMD_ROT   = 2'd0;
   localparam logic [1:0] CMD_SCALE = 2'd1;
   localparam logic [1:0] CMD_TRANS = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   localparam int CordicSteps = 30;
   localparam int IterW       = 5;
   localparam int StepW       = 4;
   localparam int AxisW       = 2;
   localparam int RotSteps    = 15;
   localparam int ScaleSteps  = 3;
   localparam int NumAxes     = 3;
   localparam int CW          = 34;

   localparam logic signed [CW-1:0] CordicGain = 34'sd652032874;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [15:0] angle_x;
      logic signed [15:0] angle_y;
      logic signed [15:0] angle_z;
      logic signed [31:0] scale_x;
      logic signed [31:0] scale_y;
      logic signed [31:0] scale_z;
      logic signed [31:0] offset_x;
      logic signed [31:0] offset_y;
      logic signed [31:0] offset_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] r00;
      logic signed [31:0] r01;
      logic signed [31:0] r02;
      logic signed [31:0] r10;
      logic signed [31:0] r11;
      logic signed [31:0] r12;
      logic signed [31:0] r20;
      logic signed [31:0] r21;
      logic signed [31:0] r22;
      logic signed [31:0] tx;
      logic signed [31:0] ty;
      logic signed [31:0] tz;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CINIT,
      ST_CITER,
      ST_CSTORE,
      ST_RMUL,
      ST_RPOST,
      ST_SMUL,
      ST_SPOST,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      OPD_SX, OPD_CX, OPD_SY, OPD_CY, OPD_SZ, OPD_CZ, OPD_SXSY, OPD_CXSY
   } operand_type;

   typedef enum logic [2:0] {
      ACT_SXSY, ACT_CXSY, ACT_TMP, ACT_SET, ACT_ADD, ACT_SUB, ACT_NEG
   } act_type;

   typedef struct packed {
      operand_type a;
      operand_type b;
      act_type     act;
      logic [3:0]  idx;
   } rot_op_type;

   typedef struct packed {
      logic             capture;
      logic             cinit;
      logic             citer;
      logic             cstore;
      logic [AxisW-1:0] axis;
      logic [IterW-1:0] iter;
      logic             rmul;
      logic             rpost;
      logic             smul;
      logic             spost;
      logic [StepW-1:0] step;
      logic             load_out;
   } ctrl_cmd_type;

   function automatic rot_op_type rot_op(input logic [StepW-1:0] step);
      rot_op_type op;
      op = '{OPD_SX, OPD_SY, ACT_SXSY, 4'd0};
      case (step)
         4'd0:    op = '{OPD_SX,   OPD_SY, ACT_SXSY, 4'd0};
         4'd1:    op = '{OPD_CX,   OPD_SY, ACT_CXSY, 4'd0};
         4'd2:    op = '{OPD_CY,   OPD_CZ, ACT_SET,  4'd0};
         4'd3:    op = '{OPD_SXSY, OPD_CZ, ACT_TMP,  4'd0};
         4'd4:    op = '{OPD_CX,   OPD_SZ, ACT_SUB,  4'd1};
         4'd5:    op = '{OPD_CXSY, OPD_CZ, ACT_TMP,  4'd0};
         4'd6:    op = '{OPD_SX,   OPD_SZ, ACT_ADD,  4'd2};
         4'd7:    op = '{OPD_CY,   OPD_SZ, ACT_SET,  4'd3};
         4'd8:    op = '{OPD_SXSY, OPD_SZ, ACT_TMP,  4'd0};
         4'd9:    op = '{OPD_CX,   OPD_CZ, ACT_ADD,  4'd4};
         4'd10:   op = '{OPD_CXSY, OPD_SZ, ACT_TMP,  4'd0};
         4'd11:   op = '{OPD_SX,   OPD_CZ, ACT_SUB,  4'd5};
         4'd12:   op = '{OPD_SY,   OPD_SY, ACT_NEG,  4'd6};
         4'd13:   op = '{OPD_SX,   OPD_CY, ACT_SET,  4'd7};
         4'd14:   op = '{OPD_CX,   OPD_CY, ACT_SET,  4'd8};
         default: op = '{OPD_SX,   OPD_SY, ACT_TMP,  4'd0};
      endcase
      return op;
   endfunction

   function automatic logic signed [CW-1:0] atan_val(input logic [IterW-1:0] i);
      logic signed [CW-1:0] v;
      v = '0;
      case (i)
         5'd0:  v = 34'sd536870912;
         5'd1:  v = 34'sd316933406;
         5'd2:  v = 34'sd167458907;
         5'd3:  v = 34'sd85004756;
         5'd4:  v = 34'sd42667331;
         5'd5:  v = 34'sd21354465;
         5'd6:  v = 34'sd10679838;
         5'd7:  v = 34'sd5340245;
         5'd8:  v = 34'sd2670163;
         5'd9:  v = 34'sd1335087;
         5'd10: v = 34'sd667544;
         5'd11: v = 34'sd333772;
         5'd12: v = 34'sd166886;
         5'd13: v = 34'sd83443;
         5'd14: v = 34'sd41722;
         5'd15: v = 34'sd20861;
         5'd16: v = 34'sd10430;
         5'd17: v = 34'sd5215;
         5'd18: v = 34'sd2608;
         5'd19: v = 34'sd1304;
         5'd20: v = 34'sd652;
         5'd21: v = 34'sd326;
         5'd22: v = 34'sd163;
         5'd23: v = 34'sd81;
         5'd24: v = 34'sd41;
         5'd25: v = 34'sd20;
         5'd26: v = 34'sd10;
         5'd27: v = 34'sd5;
         5'd28: v = 34'sd3;
         5'd29: v = 34'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

   // q2.30 sum to q16.16, round half up, saturate
   function automatic logic signed [31:0] to_q16(input logic signed [36:0] v);
      logic signed [36:0] r;
      r = (v + 37'sd8192) >>> 14;
      if (r > 37'sd2147483647)
         return 32'sh7fffffff;
      else if (r < -37'sd2147483648)
         return 32'sh80000000;
      else
         return r[31:0];
   endfunction

endpackage

// ===== hw/rtl/erm_ctrl.sv =====
// erm_ctrl: sequencing state machine for the rotation matrix builder
// drives cordic, multiply and output commands to erm_datapath; uses erm_pkg
`timescale 1ns / 1ps

module erm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_cmd,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output erm_pkg::ctrl_cmd_type ctl
);

   erm_pkg::state_type             state_ff, state_in;
   logic [erm_pkg::AxisW-1:0]      axis_ff, axis_in;
   logic [erm_pkg::IterW-1:0]      iter_ff, iter_in;
   logic [erm_pkg::StepW-1:0]      step_ff, step_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         erm_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd == erm_pkg::CMD_ROT)
                  state_in = erm_pkg::ST_CINIT;
               else if (req_cmd == erm_pkg::CMD_SCALE)
                  state_in = erm_pkg::ST_SMUL;
               else
                  state_in = erm_pkg::ST_OUT;
            end
         end
         erm_pkg::ST_CINIT: state_in = erm_pkg::ST_CITER;
         erm_pkg::ST_CITER: begin
            if (iter_ff == erm_pkg::IterW'(erm_pkg::CordicSteps - 1))
               state_in = erm_pkg::ST_CSTORE;
         end
         erm_pkg::ST_CSTORE: begin
            if (axis_ff == erm_pkg::AxisW'(erm_pkg::NumAxes - 1))
               state_in = erm_pkg::ST_RMUL;
            else
               state_in = erm_pkg::ST_CINIT;
         end
         erm_pkg::ST_RMUL: state_in = erm_pkg::ST_RPOST;
         erm_pkg::ST_RPOST: begin
            if (step_ff == erm_pkg::StepW'(erm_pkg::RotSteps - 1))
               state_in = erm_pkg::ST_OUT;
            else
               state_in = erm_pkg::ST_RMUL;
         end
         erm_pkg::ST_SMUL: state_in = erm_pkg::ST_SPOST;
         erm_pkg::ST_SPOST: begin
            if (step_ff == erm_pkg::StepW'(erm_pkg::ScaleSteps - 1))
               state_in = erm_pkg::ST_OUT;
            else
               state_in = erm_pkg::ST_SMUL;
         end
         erm_pkg::ST_OUT: begin
            if (slot_free)
               state_in = erm_pkg::ST_IDLE;
         end
         default: state_in = erm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctl          = '0;
      ctl.axis     = axis_ff;
      ctl.iter     = iter_ff;
      ctl.step     = step_ff;
      req_ready    = 1'b0;
      axis_in      = axis_ff;
      iter_in      = iter_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         erm_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            ctl.capture = req_valid;
            axis_in     = '0;
            step_in     = '0;
         end
         erm_pkg::ST_CINIT: begin
            ctl.cinit = 1'b1;
            iter_in   = '0;
         end
         erm_pkg::ST_CITER: begin
            ctl.citer = 1'b1;
            iter_in   = iter_ff + 1'b1;
         end
         erm_pkg::ST_CSTORE: begin
            ctl.cstore = 1'b1;
            axis_in    = axis_ff + 1'b1;
         end
         erm_pkg::ST_RMUL: ctl.rmul = 1'b1;
         erm_pkg::ST_RPOST: begin
            ctl.rpost = 1'b1;
            step_in   = step_ff + 1'b1;
         end
         erm_pkg::ST_SMUL: ctl.smul = 1'b1;
         erm_pkg::ST_SPOST: begin
            ctl.spost = 1'b1;
            step_in   = step_ff + 1'b1;
         end
         erm_pkg::ST_OUT: begin
            if (slot_free) begin
               ctl.load_out = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= erm_pkg::ST_IDLE;
         axis_ff      <= '0;
         iter_ff      <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         iter_ff      <= iter_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/erm_datapath.sv =====
// erm_datapath: cordic sine/cosine unit, shared multiplier and entry storage
// executes commands from erm_ctrl; uses erm_pkg
`timescale 1ns / 1ps

module erm_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  erm_pkg::ctrl_cmd_type ctl,
   input  erm_pkg::req_type      req_data,
   output erm_pkg::rsp_type      rsp_data
);

   localparam int CW = erm_pkg::CW;

   erm_pkg::req_type     req_ff;
   logic signed [31:0]   rot_ff [9];
   logic signed [31:0]   trans_ff [3];
   logic signed [CW-1:0] sin_ff [3];
   logic signed [CW-1:0] cos_ff [3];
   logic signed [CW-1:0] x_ff, y_ff, z_ff;
   logic                 neg_ff;
   logic signed [CW-1:0] sxsy_ff, cxsy_ff;
   logic signed [35:0]   tmp_ff;
   logic signed [67:0]   prod_ff;
   erm_pkg::rsp_type     rsp_ff;

   logic signed [15:0]   angle;
   logic [31:0]          phase;
   logic signed [CW-1:0] xs, ys, atan;
   erm_pkg::rot_op_type  op;
   logic signed [CW-1:0] mul_a, mul_b;
   logic signed [67:0]   rnd30, rnd16;
   logic signed [35:0]   r30;
   logic signed [36:0]   sum;
   logic signed [31:0]   scaled;
   logic [3:0]           diag_idx;

   function automatic logic signed [CW-1:0] opd(input erm_pkg::operand_type s,
         input logic signed [CW-1:0] sx, input logic signed [CW-1:0] cx,
         input logic signed [CW-1:0] sy, input logic signed [CW-1:0] cy,
         input logic signed [CW-1:0] sz, input logic signed [CW-1:0] cz,
         input logic signed [CW-1:0] sxsy, input logic signed [CW-1:0] cxsy);
      logic signed [CW-1:0] v;
      v = sx;
      case (s)
         erm_pkg::OPD_SX:   v = sx;
         erm_pkg::OPD_CX:   v = cx;
         erm_pkg::OPD_SY:   v = sy;
         erm_pkg::OPD_CY:   v = cy;
         erm_pkg::OPD_SZ:   v = sz;
         erm_pkg::OPD_CZ:   v = cz;
         erm_pkg::OPD_SXSY: v = sxsy;
         erm_pkg::OPD_CXSY: v = cxsy;
         default:           v = sx;
      endcase
      return v;
   endfunction

   always_comb begin
      case (ctl.axis)
         2'd0:    angle = req_ff.angle_x;
         2'd1:    angle = req_ff.angle_y;
         default: angle = req_ff.angle_z;
      endcase
      phase = {angle, 16'h0000};
   end

   assign xs   = x_ff >>> ctl.iter;
   assign ys   = y_ff >>> ctl.iter;
   assign atan = erm_pkg::atan_val(ctl.iter);

   assign op       = erm_pkg::rot_op(ctl.step);
   assign diag_idx = 4'(ctl.step * 3'd4);

   always_comb begin
      if (ctl.smul) begin
         mul_a = CW'(rot_ff[diag_idx]);
         case (ctl.step[1:0])
            2'd0:    mul_b = CW'(req_ff.scale_x);
            2'd1:    mul_b = CW'(req_ff.scale_y);
            default: mul_b = CW'(req_ff.scale_z);
         endcase
      end else begin
         mul_a = opd(op.a, sin_ff[0], cos_ff[0], sin_ff[1], cos_ff[1],
                     sin_ff[2], cos_ff[2], sxsy_ff, cxsy_ff);
         mul_b = opd(op.b, sin_ff[0], cos_ff[0], sin_ff[1], cos_ff[1],
                     sin_ff[2], cos_ff[2], sxsy_ff, cxsy_ff);
      end
   end

   always_comb begin
      rnd30 = (prod_ff + 68'sd536870912) >>> 30;
      r30   = rnd30[35:0];
      rnd16 = (prod_ff + 68'sd32768) >>> 16;
      if (rnd16 > 68'sd2147483647)
         scaled = 32'sh7fffffff;
      else if (rnd16 < -68'sd2147483648)
         scaled = 32'sh80000000;
      else
         scaled = rnd16[31:0];
      case (op.act)
         erm_pkg::ACT_ADD: sum = 37'(tmp_ff) + 37'(r30);
         erm_pkg::ACT_SUB: sum = 37'(tmp_ff) - 37'(r30);
         erm_pkg::ACT_NEG: sum = -37'(sin_ff[1]);
         default:          sum = 37'(r30);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++)
            rot_ff[i] <= '0;
         for (int i = 0; i < 3; i++)
            trans_ff[i] <= '0;
      end else begin
         if (ctl.capture && req_data.cmd == erm_pkg::CMD_TRANS) begin
            trans_ff[0] <= req_data.offset_x;
            trans_ff[1] <= req_data.offset_y;
            trans_ff[2] <= req_data.offset_z;
         end
         if (ctl.rpost) begin
            case (op.act)
               erm_pkg::ACT_SET, erm_pkg::ACT_ADD, erm_pkg::ACT_SUB,
               erm_pkg::ACT_NEG: rot_ff[op.idx] <= erm_pkg::to_q16(sum);
               default: ;
            endcase
         end
         if (ctl.spost)
            rot_ff[diag_idx] <= scaled;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture)
         req_ff <= req_data;
      if (ctl.cinit) begin
         x_ff   <= erm_pkg::CordicGain;
         y_ff   <= '0;
         neg_ff <= phase[31] ^ phase[30];
         z_ff   <= CW'($signed({phase[31] ^ (phase[31] ^ phase[30]), phase[30:0]}));
      end
      if (ctl.citer) begin
         if (!z_ff[CW-1]) begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - atan;
         end else begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + atan;
         end
      end
      if (ctl.cstore) begin
         sin_ff[ctl.axis] <= neg_ff ? -y_ff : y_ff;
         cos_ff[ctl.axis] <= neg_ff ? -x_ff : x_ff;
      end
      if (ctl.rmul || ctl.smul)
         prod_ff <= mul_a * mul_b;
      if (ctl.rpost) begin
         case (op.act)
            erm_pkg::ACT_SXSY: sxsy_ff <= CW'(r30);
            erm_pkg::ACT_CXSY: cxsy_ff <= CW'(r30);
            erm_pkg::ACT_TMP:  tmp_ff  <= r30;
            default: ;
         endcase
      end
      if (ctl.load_out) begin
         rsp_ff.r00 <= rot_ff[0];
         rsp_ff.r01 <= rot_ff[1];
         rsp_ff.r02 <= rot_ff[2];
         rsp_ff.r10 <= rot_ff[3];
         rsp_ff.r11 <= rot_ff[4];
         rsp_ff.r12 <= rot_ff[5];
         rsp_ff.r20 <= rot_ff[6];
         rsp_ff.r21 <= rot_ff[7];
         rsp_ff.r22 <= rot_ff[8];
         rsp_ff.tx  <= trans_ff[0];
         rsp_ff.ty  <= trans_ff[1];
         rsp_ff.tz  <= trans_ff[2];
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== hw/rtl/euler_rotation_matrix_builder.sv =====
// euler_rotation_matrix_builder: top level of the euler angle matrix builder
// instantiates erm_ctrl and erm_datapath; uses erm_pkg
`timescale 1ns / 1ps
//
// usage
//   req channel (req_valid/req_ready/req_data) takes one command per transaction:
//   cmd 0 builds the 3x3 part from three binary angles, cmd 1 scales the
//   diagonal, cmd 2 loads the translation row, cmd 3 only reads back.
//   rsp channel (rsp_valid/rsp_ready/rsp_data) returns all twelve entries,
//   signed q16.16, once per request transaction.
//   from accept to rsp_valid: cmd 0 runs three cordic passes (init, iterate,
//   store) on one shared sine/cosine unit, fifteen multiply/post steps of one
//   multiplier, then one output load; cmd 1 runs three multiply/post steps,
//   then one output load; cmd 2 and 3 go straight to the output load.
//   one request is worked on at a time; req_ready is high only when idle, in
//   the cycle after the load; a new request waits until the last is loaded.
//   the result sits in an output register, so a new request is taken while a
//   result is still waiting; a stalled receiver holds back only the next load.
//   reset clears the matrix and translation to zero and drops rsp_valid.
//
module euler_rotation_matrix_builder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  erm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output erm_pkg::rsp_type rsp_data
);

   erm_pkg::ctrl_cmd_type ctl;

   erm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_data.cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctl       (ctl)
   );

   erm_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

// ===== dv/euler_rotation_matrix_builder_test.sv =====
// euler_rotation_matrix_builder_test: self-checking bench for the euler rotation matrix builder
// drives random and directed commands, predicts all twelve entries in a scoreboard class
// depends on erm_pkg and euler_rotation_matrix_builder
`timescale 1ns / 1ps

module euler_rotation_matrix_builder_test;

   localparam longint CycleLimit = 1_500_000;
   localparam int RandItems = 900;

   class matrix_scoreboard;
      logic signed [31:0] rot[9];
      logic signed [31:0] trans[3];
      erm_pkg::rsp_type pending[$];
      int errors;

      function new();
         foreach (rot[i]) rot[i] = '0;
         foreach (trans[i]) trans[i] = '0;
         errors = 0;
      endfunction

      function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function void sin_cos(logic [15:0] ang, output longint s, output longint c);
         logic [31:0] ph;
         logic [1:0] quad;
         bit neg;
         longint x, y, z, xn;
         ph = {ang, 16'h0};
         quad = ph[31:30];
         neg = (quad == 2'd1 || quad == 2'd2);
         if (neg) ph = ph + 32'h8000_0000;
         x = 652032874;
         y = 0;
         z = longint'($signed(ph));
         for (int i = 0; i < erm_pkg::CordicSteps; i++) begin
            if (z >= 0) begin
               xn = x - (y >>> i);
               y = y + (x >>> i);
               z = z - longint'(erm_pkg::atan_val(5'(i)));
            end else begin
               xn = x + (y >>> i);
               y = y - (x >>> i);
               z = z + longint'(erm_pkg::atan_val(5'(i)));
            end
            x = xn;
         end
         s = neg ? -y : y;
         c = neg ? -x : x;
      endfunction

      function longint mul_q30(longint a, longint b);
         return (a * b + (64'sd1 <<< 29)) >>> 30;
      endfunction

      function logic signed [31:0] q30_to_q16(longint v);
         return 32'(clamp32((v + 8192) >>> 14));
      endfunction

      function logic signed [31:0] scaled(logic signed [31:0] e, logic signed [31:0] f);
         return 32'(clamp32((longint'(e) * longint'(f) + 32768) >>> 16));
      endfunction

      function void note_request(erm_pkg::req_type r);
         longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
         erm_pkg::rsp_type e;
         if (r.cmd == erm_pkg::CMD_ROT) begin
            sin_cos(r.angle_x, sx, cx);
            sin_cos(r.angle_y, sy, cy);
            sin_cos(r.angle_z, sz, cz);
            sxsy = mul_q30(sx, sy);
            cxsy = mul_q30(cx, sy);
            rot[0] = q30_to_q16(mul_q30(cy, cz));
            rot[1] = q30_to_q16(mul_q30(sxsy, cz) - mul_q30(cx, sz));
            rot[2] = q30_to_q16(mul_q30(cxsy, cz) + mul_q30(sx, sz));
            rot[3] = q30_to_q16(mul_q30(cy, sz));
            rot[4] = q30_to_q16(mul_q30(sxsy, sz) + mul_q30(cx, cz));
            rot[5] = q30_to_q16(mul_q30(cxsy, sz) - mul_q30(sx, cz));
            rot[6] = q30_to_q16(-sy);
            rot[7] = q30_to_q16(mul_q30(sx, cy));
            rot[8] = q30_to_q16(mul_q30(cx, cy));
         end else if (r.cmd == erm_pkg::CMD_SCALE) begin
            rot[0] = scaled(rot[0], r.scale_x);
            rot[4] = scaled(rot[4], r.scale_y);
            rot[8] = scaled(rot[8], r.scale_z);
         end else if (r.cmd == erm_pkg::CMD_TRANS) begin
            trans[0] = r.offset_x;
            trans[1] = r.offset_y;
            trans[2] = r.offset_z;
         end
         e = '{rot[0], rot[1], rot[2], rot[3], rot[4], rot[5], rot[6], rot[7], rot[8],
               trans[0], trans[1], trans[2]};
         pending.push_back(e);
      endfunction

      function void compare(string name, logic signed [31:0] exp_v, logic signed [31:0] act_v);
         if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d actual %0d", name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_response(erm_pkg::rsp_type a);
         erm_pkg::rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected response transaction");
            errors++;
            return;
         end
         e = pending.pop_front();
         compare("r00", e.r00, a.r00); compare("r01", e.r01, a.r01);
         compare("r02", e.r02, a.r02); compare("r10", e.r10, a.r10);
         compare("r11", e.r11, a.r11); compare("r12", e.r12, a.r12);
         compare("r20", e.r20, a.r20); compare("r21", e.r21, a.r21);
         compare("r22", e.r22, a.r22); compare("tx", e.tx, a.tx);
         compare("ty", e.ty, a.ty); compare("tz", e.tz, a.tz);
      endfunction
   endclass

   logic clock, reset, req_valid, req_ready, rsp_valid, rsp_ready;
   erm_pkg::req_type req_data;
   erm_pkg::rsp_type rsp_data;
   matrix_scoreboard sb;
   longint cycles;
   bit calm;      // no idling on either side
   bit hold_rsp;  // long receiver hold-off

   euler_rotation_matrix_builder u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      sb = new();
      calm = 1'b0;
      hold_rsp = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         cycles <= 0;
      end else begin
         cycles <= cycles + 1;
         if (req_valid && req_ready) sb.note_request(req_data);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
         if (cycles > CycleLimit) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (reset || hold_rsp)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 37);
   end

   // called at a falling edge; leaves valid high after acceptance
   task automatic send(erm_pkg::req_type r);
      if (!calm) begin
         while ($urandom_range(99) < 37) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_data <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_angle();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return {2'($urandom_range(3)), 14'h0};
         3: return 16'($urandom_range(7)) - 16'd3;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_scale();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'($urandom_range(4'hf)) <<< $urandom_range(20);
         3: return -(32'($urandom_range(4'hf)) <<< $urandom_range(20));
         default: return $urandom;
      endcase
   endfunction

   function automatic erm_pkg::req_type random_request();
      erm_pkg::req_type r;
      r.cmd = ($urandom_range(19) == 0) ? erm_pkg::CMD_READ : 2'($urandom_range(2));
      r.angle_x = pick_angle(); r.angle_y = pick_angle(); r.angle_z = pick_angle();
      r.scale_x = pick_scale(); r.scale_y = pick_scale(); r.scale_z = pick_scale();
      if ($urandom_range(3) == 0) begin
         r.scale_y = r.scale_x;
         r.scale_z = r.scale_x;
      end
      r.offset_x = $urandom; r.offset_y = $urandom; r.offset_z = $urandom;
      return r;
   endfunction

   // called at a falling edge; drops valid, then waits for every result
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      erm_pkg::req_type r;
      logic [15:0] dir_angles[6];
      int n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      dir_angles = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'h7fff, 16'h2000};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // scale before any rotation, read-back, translation extremes
      r = '0;
      r.cmd = erm_pkg::CMD_SCALE; r.scale_x = 32'h7fff_ffff; r.scale_y = 32'h8000_0000;
      r.scale_z = 32'h0001_0000;
      send(r);
      r = '1; r.cmd = erm_pkg::CMD_READ; send(r);
      r = '0; r.cmd = erm_pkg::CMD_TRANS;
      r.offset_x = 32'h7fff_ffff; r.offset_y = 32'h8000_0000; r.offset_z = 32'hffff_ffff;
      send(r);
      foreach (dir_angles[i]) begin
         r = '0; r.cmd = erm_pkg::CMD_ROT;
         r.angle_x = dir_angles[i]; r.angle_y = dir_angles[(i + 1) % 6];
         r.angle_z = dir_angles[(i + 2) % 6];
         send(r);
      end
      r = '0; r.cmd = erm_pkg::CMD_ROT; send(r);
      r.cmd = erm_pkg::CMD_SCALE;
      r.scale_x = 32'h7fff_ffff; r.scale_y = 32'h8000_0000; r.scale_z = 32'h8000_0000;
      send(r);
      r = '0; r.cmd = erm_pkg::CMD_ROT; send(r);
      r.cmd = erm_pkg::CMD_SCALE;
      r.scale_x = 32'h0002_0000; r.scale_y = 32'h0002_0000; r.scale_z = 32'h0002_0000;
      send(r);
      r = '1; r.cmd = erm_pkg::CMD_TRANS; send(r);

      // pause until drained, then a long receiver stall
      wait_drained();
      fork
         begin
            hold_rsp = 1'b1;
            repeat (400) @(posedge clock);
            @(negedge clock);
            hold_rsp = 1'b0;
         end
         begin
            @(negedge clock);
            for (int k = 0; k < 6; k++) send(random_request());
         end
      join

      n = 0;
      while (n < RandItems) begin
         calm = (n >= 300 && n < 380);
         send(random_request());
         n++;
      end
      calm = 1'b0;

      wait_drained();
      repeat (300) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
